/* rtl/core/lcgr_pkg.sv */
// ----------------------------------------------------------------------------
// lcgr_pkg
// Shared constants and controller/datapath interface types for the 64-bit
// linear congruential random source.
// ----------------------------------------------------------------------------
package lcgr_pkg;

  localparam logic [63:0] LCG_MULT    = 64'd6364136223846793005;
  localparam logic [63:0] LCG_INC     = 64'd1442695040888963407;
  localparam logic [31:0] LCG_MULT_LO = LCG_MULT[31:0];
  localparam logic [31:0] LCG_MULT_HI = LCG_MULT[63:32];

  // Datapath operations issued by the controller.
  typedef logic [2:0] dp_op_t;
  localparam dp_op_t OP_NONE = 3'd0;  // hold
  localparam dp_op_t OP_LOAD = 3'd1;  // capture request, low x low product
  localparam dp_op_t OP_MUL1 = 3'd2;  // add increment, high x low product
  localparam dp_op_t OP_MUL2 = 3'd3;  // add cross term, low x high product
  localparam dp_op_t OP_MUL3 = 3'd4;  // add last cross term
  localparam dp_op_t OP_PREP = 3'd5;  // commit seed, set up the division
  localparam dp_op_t OP_DIV  = 3'd6;  // one restoring division step

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
    logic   seed_wr;
  } lcgr_cmd_t;

  typedef struct packed {
    logic div_needed;
    logic div_last;
  } lcgr_status_t;

endpackage

/* rtl/core/lcgr_dp.sv */
// ----------------------------------------------------------------------------
// lcgr_dp
// Datapath: seed register, shared 32x32 multiplier, restoring divider for
// the range reduction, and the result register.
// ----------------------------------------------------------------------------
module lcgr_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  lcgr_pkg::lcgr_cmd_t  cmd,
  output lcgr_pkg::lcgr_status_t status,
  input  logic                 in_mode,
  input  logic [63:0]          in_low,
  input  logic [63:0]          in_high,
  input  logic [63:0]          cfg_data,
  output logic [63:0]          out_value,
  output logic                 out_err
);
  import lcgr_pkg::*;

  logic [63:0] seed;
  logic        mode_r;
  logic [63:0] low_r;
  logic [63:0] high_r;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [63:0] divisor;
  logic [63:0] dividend;
  logic [63:0] rem;
  logic [5:0]  cnt;
  logic        err_r;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [64:0] rem_sh;
  logic [64:0] rem_sub;
  logic        range_ok;
  logic [63:0] result;

  assign mul_a    = (cmd.op == OP_MUL1) ? seed[63:32] : seed[31:0];
  assign mul_b    = (cmd.op == OP_MUL2) ? LCG_MULT_HI : LCG_MULT_LO;
  assign mul_p    = {32'd0, mul_a} * {32'd0, mul_b};
  assign rem_sh   = {rem, dividend[63]};
  assign rem_sub  = rem_sh - {1'b0, divisor};
  assign range_ok = low_r < high_r;

  assign status.div_needed = mode_r && range_ok;
  assign status.div_last   = (cnt == '0);

  // Raw mode returns the new seed; an empty range returns its lower bound.
  always_comb begin
    priority if (err_r) begin
      result = low_r;
    end else if (mode_r) begin
      result = rem + low_r;
    end else begin
      result = seed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cmd.seed_wr) begin
      seed <= cfg_data;
    end else if (cmd.op == OP_PREP) begin
      seed <= acc;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        mode_r <= in_mode;
        low_r  <= in_low;
        high_r <= in_high;
        prod   <= mul_p;
      end
      OP_MUL1: begin
        acc  <= prod + LCG_INC;
        prod <= mul_p;
      end
      OP_MUL2: begin
        acc  <= acc + {prod[31:0], 32'd0};
        prod <= mul_p;
      end
      OP_MUL3: begin
        acc <= acc + {prod[31:0], 32'd0};
      end
      OP_PREP: begin
        divisor  <= high_r - low_r;
        dividend <= acc;
        rem      <= '0;
        cnt      <= 6'd63;
        err_r    <= mode_r && !range_ok;
      end
      OP_DIV: begin
        rem      <= rem_sub[64] ? rem_sh[63:0] : rem_sub[63:0];
        dividend <= {dividend[62:0], 1'b0};
        cnt      <= cnt - 6'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value <= result;
      out_err   <= err_r;
    end
  end

`ifndef SYNTHESIS
  // The partial remainder always stays below a nonzero divisor.
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DIV) |-> (rem < divisor))
    else $error("remainder not below divisor");
`endif

endmodule

/* rtl/core/lcgr_ctrl.sv */
// ----------------------------------------------------------------------------
// lcgr_ctrl
// Controller: sequences the multiply, the division and the result hand-off,
// and owns the handshakes of all three channels.
// ----------------------------------------------------------------------------
module lcgr_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_valid,
  output logic                   s_ready,
  output logic                   m_valid,
  input  logic                   m_ready,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  lcgr_pkg::lcgr_status_t status,
  output lcgr_pkg::lcgr_cmd_t    cmd
);
  import lcgr_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_MUL2 = 3'd2;
  localparam logic [2:0] ST_MUL3 = 3'd3;
  localparam logic [2:0] ST_PREP = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid;
  logic       out_free;

  assign out_free  = !out_valid || m_ready;
  assign cfg_ready = (state == ST_IDLE);
  assign s_ready   = (state == ST_IDLE) && !cfg_valid;
  assign m_valid   = out_valid;

  always_comb begin
    state_next   = state;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    cmd.seed_wr  = cfg_valid && cfg_ready;
    unique case (state)
      ST_IDLE: begin
        if (s_valid && s_ready) begin
          cmd.op     = OP_LOAD;
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.op     = OP_MUL1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.op     = OP_MUL2;
        state_next = ST_MUL3;
      end
      ST_MUL3: begin
        cmd.op     = OP_MUL3;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.op     = OP_PREP;
        state_next = status.div_needed ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        cmd.op = OP_DIV;
        if (status.div_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_mul: assert property (@(posedge clk) disable iff (rst)
    (s_valid && s_ready) |=> (state == ST_MUL1))
    else $error("accepted request did not start the multiply");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || m_ready))
    else $error("result register overwritten while still pending");

  a_cfg_excludes_input: assert property (@(posedge clk) disable iff (rst)
    !(cfg_valid && cfg_ready && s_valid && s_ready))
    else $error("seed write and request accepted together");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("result loaded but not presented");
`endif

endmodule

/* rtl/core/lcg64_ranged_random.sv */
// ----------------------------------------------------------------------------
// lcg64_ranged_random
// 64-bit linear congruential random source with optional range reduction.
// ----------------------------------------------------------------------------
// Each request beat advances a 64-bit seed with seed * 6364136223846793005 +
// 1442695040888963407 (mod 2^64) and returns one result beat. With mode 0
// the result is the new seed; with mode 1 it is (seed mod (high - low)) + low,
// keeping the small bias of a plain modulo. In mode 1 an empty or inverted range returns
// range_low with range_error set, and the seed still advances. Writing the
// configuration channel loads the seed at once; it is accepted only while no
// request is in flight. The multiply is split over one shared 32x32
// multiplier in four steps; in ranged mode with a valid range the modulo
// follows as a restoring divider that retires one quotient bit per cycle,
// 64 bits in all, and is skipped otherwise. A finished result waits
// in an output register, so the next request can already be accepted and
// worked on while the previous beat is still held by the consumer.
// ----------------------------------------------------------------------------
module lcg64_ranged_random (
  input  logic          clk,
  input  logic          rst,
  // Request channel.
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [127:0]  s_axis_tdata,   // [63:0] range_low, [127:64] range_high
  input  logic          s_axis_tuser,   // [0] mode
  // Result channel.
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [63:0]   m_axis_tdata,   // [63:0] random_value
  output logic          m_axis_tuser,   // [0] range_error
  // Seed write channel.
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [63:0]   cfg_data        // seed_value
);
  import lcgr_pkg::*;

  lcgr_cmd_t    cmd;
  lcgr_status_t status;

  // The controller runs the sequence and the handshakes; all arithmetic and
  // the result payload live in the datapath.
  lcgr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_axis_tvalid),
    .s_ready   (s_axis_tready),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lcgr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_mode   (s_axis_tuser),
    .in_low    (s_axis_tdata[63:0]),
    .in_high   (s_axis_tdata[127:64]),
    .cfg_data  (cfg_data),
    .out_value (m_axis_tdata),
    .out_err   (m_axis_tuser)
  );

endmodule
